FILE: rtl/core/sgm_pkg.sv
// shared types and constants of the sobel gradient magnitude block
// no dependencies
`default_nettype none

package sgm_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CfgIdxBits-1:0] REG_FRAME_HEIGHT = 1'd1;
  localparam int unsigned CfgDataBits = 13;

  // field widths
  localparam int unsigned FrameWidthBits  = 11;
  localparam int unsigned FrameHeightBits = 13;
  localparam int unsigned IntensityBits   = 8;
  localparam int unsigned MagBits         = 11;
  localparam int unsigned RowBits         = 12;
  localparam int unsigned ColBits         = 10;
  localparam int unsigned OutDataBits     = 56;

  // reset values and limits
  localparam logic [FrameWidthBits-1:0]  FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FrameHeightBits-1:0] FRAME_HEIGHT_RESET = 13'd480;
  localparam int unsigned MinFrameDim = 3;
  localparam int unsigned MaxHeight   = 4096;
  localparam int unsigned MagResetMin = 1442;
  localparam int unsigned MagSat      = 2047;

  // status of the square root unit
  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/sobel_gradient_magnitude_top.sv
// top level of the 3x3 sobel gradient magnitude block
// depends on sgm_pkg, sgm_ram, sgm_isqrt
// a border pixel is accepted and read from the line stores; an interior pixel then squares
//   its gradients, loads and runs the bit-serial square root unit and hands the result to
//   the output register, waiting while that register is full; one pixel is in flight at a
//   time, and the output register lets the next pixel start while a result waits to be
//   taken
// reset: asynchronous, active low; line stores are not cleared, no clearing pass
`default_nettype none

module sobel_gradient_magnitude_top
  import sgm_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write channel
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [CfgIdxBits-1:0]    cfg_index_i,
  input  wire logic [CfgDataBits-1:0]   cfg_data_i,
  // pixel input stream
  input  wire logic                     s_axis_tvalid,
  output      logic                     s_axis_tready,
  input  wire logic [IntensityBits-1:0] s_axis_tdata,  // intensity[7:0]
  input  wire logic                     s_axis_tuser,  // frame_start
  // magnitude output stream
  output      logic                     m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // magnitude[10:0], center_row[22:11], center_col[32:23], frame_max[43:33],
  // frame_min[54:44], zero pad[55]
  output      logic [OutDataBits-1:0]   m_axis_tdata,
  output      logic                     m_axis_tlast   // last_of_frame
);

  // widths that follow from the parameters
  localparam int unsigned CW   = $clog2(MAX_WIDTH);          // column counter
  localparam int unsigned EW   = (CW + 1 > FrameWidthBits) ? CW + 1 : FrameWidthBits;
  localparam int unsigned GW   = PIXEL_BITS + 2;             // |gx|, |gy|
  localparam int unsigned SQW  = 2 * GW;                     // squares
  localparam int unsigned RADW = SQW + 1;                    // sum of squares
  localparam int unsigned RTW  = (RADW + 1) / 2;             // root

  // sequencer states
  localparam logic [2:0] StIdle   = 3'd0;  // waiting for a pixel request
  localparam logic [2:0] StRead   = 3'd1;  // line store data arrives
  localparam logic [2:0] StSquare = 3'd2;  // square the gradients
  localparam logic [2:0] StStart  = 3'd3;  // add squares, load root unit
  localparam logic [2:0] StRoot   = 3'd4;  // root unit iterating
  localparam logic [2:0] StEmit   = 3'd5;  // hand result to output register

  logic [2:0] state_q, state_d;

  // configuration
  logic [FrameWidthBits-1:0]  frame_width_q;
  logic [FrameHeightBits-1:0] frame_height_q;
  logic [FrameWidthBits-1:0]  width_eff;
  logic [FrameHeightBits-1:0] height_eff;

  // position of the next pixel and frame extremes
  logic [CW-1:0]      col_q;
  logic [RowBits-1:0] row_q;
  logic [MagBits-1:0] max_q;
  logic [MagBits-1:0] min_q;

  // sliding window: 0..2 left column (top, mid, bottom), 3..5 middle column
  logic [PIXEL_BITS-1:0] win_q [6];
  logic [PIXEL_BITS-1:0] px_q;

  // per-pixel context kept while the root is worked out
  logic               last_q;
  logic [RowBits-1:0] cen_row_q;
  logic [ColBits-1:0] cen_col_q;
  logic [GW-1:0]      abs_gx_q;
  logic [GW-1:0]      abs_gy_q;
  logic [SQW-1:0]     sq_x_q;
  logic [SQW-1:0]     sq_y_q;

  // output register
  logic                   out_valid_q;
  logic [OutDataBits-1:0] out_data_q;
  logic                   out_last_q;

  // handshakes
  logic in_req;
  logic out_free;
  assign s_axis_tready = (state_q == StIdle);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // register clamping
  always_comb begin
    if (frame_width_q < FrameWidthBits'(MinFrameDim)) begin
      width_eff = FrameWidthBits'(MinFrameDim);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      width_eff = FrameWidthBits'(MAX_WIDTH);
    end else begin
      width_eff = frame_width_q;
    end
    if (frame_height_q < FrameHeightBits'(MinFrameDim)) begin
      height_eff = FrameHeightBits'(MinFrameDim);
    end else if (32'(frame_height_q) > MaxHeight) begin
      height_eff = FrameHeightBits'(MaxHeight);
    end else begin
      height_eff = frame_height_q;
    end
  end

  // line stores: a holds the previous row, b the row before it
  logic [CW-1:0]         rd_addr;
  logic [PIXEL_BITS-1:0] rd_a;
  logic [PIXEL_BITS-1:0] rd_b;
  logic                  wr_en;

  assign rd_addr = s_axis_tuser ? '0 : col_q;
  assign wr_en   = (state_q == StRead);

  sgm_ram #(
    .Width (PIXEL_BITS),
    .Depth (MAX_WIDTH)
  ) u_line_a (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (col_q),
    .wdata_i (px_q),
    .re_i    (in_req),
    .raddr_i (rd_addr),
    .rdata_o (rd_a)
  );

  sgm_ram #(
    .Width (PIXEL_BITS),
    .Depth (MAX_WIDTH)
  ) u_line_b (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (col_q),
    .wdata_i (rd_a),
    .re_i    (in_req),
    .raddr_i (rd_addr),
    .rdata_o (rd_b)
  );

  // gradients from the window and the line store outputs
  logic [GW-1:0] gx_pos, gx_neg, gy_pos, gy_neg;
  logic [GW-1:0] abs_gx, abs_gy;
  logic          interior;
  logic          col_last;
  logic          row_last;

  assign gx_pos = GW'(rd_b) + (GW'(rd_a) << 1) + GW'(px_q);
  assign gx_neg = GW'(win_q[0]) + (GW'(win_q[1]) << 1) + GW'(win_q[2]);
  assign gy_pos = GW'(win_q[2]) + (GW'(win_q[5]) << 1) + GW'(px_q);
  assign gy_neg = GW'(win_q[0]) + (GW'(win_q[3]) << 1) + GW'(rd_b);
  assign abs_gx = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
  assign abs_gy = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;

  assign interior = (row_q >= RowBits'(2)) && (col_q >= CW'(2));
  assign col_last = (EW'(col_q) + EW'(1)) >= EW'(width_eff);
  assign row_last = (FrameHeightBits'(row_q) + FrameHeightBits'(1)) >= height_eff;

  // square root unit
  sqrt_stat_t     sqrt_stat;
  logic [RTW-1:0] root;
  logic           sqrt_start;

  assign sqrt_start = (state_q == StStart);

  sgm_isqrt #(
    .InBits (RADW)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (RADW'(sq_x_q) + RADW'(sq_y_q)),
    .stat_o     (sqrt_stat),
    .root_o     (root)
  );

  // saturated magnitude and updated extremes
  logic [MagBits-1:0] mag;
  logic [MagBits-1:0] new_max;
  logic [MagBits-1:0] new_min;

  assign mag     = (32'(root) > MagSat) ? MagBits'(MagSat) : MagBits'(root);
  assign new_max = (mag > max_q) ? mag : max_q;
  assign new_min = (mag < min_q) ? mag : min_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_req) begin
          state_d = StRead;
        end
      end
      StRead: begin
        state_d = interior ? StSquare : StIdle;
      end
      StSquare: begin
        state_d = StStart;
      end
      StStart: begin
        state_d = StRoot;
      end
      StRoot: begin
        if (sqrt_stat.done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      frame_width_q  <= FRAME_WIDTH_RESET;
      frame_height_q <= FRAME_HEIGHT_RESET;
      col_q          <= '0;
      row_q          <= '0;
      max_q          <= '0;
      min_q          <= MagBits'(MagResetMin);
      out_valid_q    <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      // configuration writes
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FrameWidthBits-1:0];
          REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FrameHeightBits-1:0];
          default: ;
        endcase
      end

      // frame start restarts position and extremes before the pixel is used
      if (in_req && s_axis_tuser) begin
        col_q <= '0;
        row_q <= '0;
        max_q <= '0;
        min_q <= MagBits'(MagResetMin);
      end

      if (state_q == StRead) begin
        // shift the window one column left
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= rd_b;
        win_q[4] <= rd_a;
        win_q[5] <= px_q;
        // advance position, wrap at end of row and frame
        if (col_last) begin
          col_q <= '0;
          row_q <= row_last ? '0 : row_q + RowBits'(1);
          // border pixel closing the frame clears extremes here
          if (row_last && !interior) begin
            max_q <= '0;
            min_q <= MagBits'(MagResetMin);
          end
        end else begin
          col_q <= col_q + CW'(1);
        end
      end

      if (state_q == StEmit && out_free) begin
        // extremes include this result, then clear after the frame's last one
        max_q <= last_q ? '0 : new_max;
        min_q <= last_q ? MagBits'(MagResetMin) : new_min;
      end

      // output register
      if (state_q == StEmit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      px_q <= PIXEL_BITS'(s_axis_tdata);
    end
    if (state_q == StRead) begin
      abs_gx_q  <= abs_gx;
      abs_gy_q  <= abs_gy;
      cen_row_q <= row_q - RowBits'(1);
      cen_col_q <= ColBits'(col_q - CW'(1));
      last_q    <= col_last && row_last;
    end
    if (state_q == StSquare) begin
      sq_x_q <= SQW'(abs_gx_q) * SQW'(abs_gx_q);
      sq_y_q <= SQW'(abs_gy_q) * SQW'(abs_gy_q);
    end
    if (state_q == StEmit && out_free) begin
      out_data_q <= {1'b0, new_min, new_max, cen_col_q, cen_row_q, mag};
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/sgm_ram.sv
// generic single-write single-read synchronous ram with registered read
// no dependencies
`default_nettype none

module sgm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/sgm_isqrt.sv
// iterative integer square root, one root bit per cycle
// depends on sgm_pkg
`default_nettype none

module sgm_isqrt
  import sgm_pkg::*;
#(
  parameter int unsigned InBits = 21
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [InBits-1:0]          radicand_i,
  output      sqrt_stat_t                 stat_o,
  output      logic [(InBits+1)/2-1:0]    root_o
);

  localparam int unsigned RootBits = (InBits + 1) / 2;
  localparam int unsigned PadBits  = 2 * RootBits;
  localparam int unsigned RemBits  = RootBits + 2;
  localparam int unsigned CntBits  = $clog2(RootBits + 1);

  logic [PadBits-1:0]  rad_q, rad_d;
  logic [RemBits-1:0]  rem_q, rem_d;
  logic [RootBits-1:0] root_q, root_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                done_q, done_d;

  logic [RemBits-1:0] rem_shift;
  logic [RemBits-1:0] trial;

  // bring down the next two radicand bits and try a one in the root
  assign rem_shift = {rem_q[RootBits-1:0], rad_q[PadBits-1 -: 2]};
  assign trial     = {root_q, 2'b01};

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = PadBits'(radicand_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = CntBits'(RootBits);
    end else if (cnt_q != '0) begin
      rad_d = {rad_q[PadBits-3:0], 2'b00};
      if (rem_shift >= trial) begin
        rem_d  = rem_shift - trial;
        root_d = {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_d  = rem_shift;
        root_d = {root_q[RootBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

`default_nettype wire

FILE: rtl/core/sgm_checker.sv
// port-level checks for the sobel gradient magnitude top level, bound to it
// depends on sgm_pkg
`default_nettype none

module sgm_checker
  import sgm_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     s_axis_tvalid,
  input wire logic                     s_axis_tready,
  input wire logic                     m_axis_tvalid,
  input wire logic                     m_axis_tready,
  input wire logic [OutDataBits-1:0]   m_axis_tdata,
  input wire logic                     m_axis_tlast
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // one pixel in flight: no request right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while a pixel is in flight");

  // extremes bracket the magnitude they include
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[43:33] >= m_axis_tdata[10:0]) &&
      (m_axis_tdata[54:44] <= m_axis_tdata[10:0]))
    else $error("frame extremes do not bracket magnitude");

  // pad bit stays clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[55])
    else $error("pad bit set");

endmodule

bind sobel_gradient_magnitude_top sgm_checker u_sgm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench for sobel_gradient_magnitude_top
// holds a pixel-exact sobel predictor in a small scoreboard class; plain tasks drive
// the config and pixel channels, an always block the magnitude ready; depends on sgm_pkg and the block rtl
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sgm_pkg::*;

  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned PIXEL_BITS    = 8;
  // settle time after the last magnitude, with margin over an interior pixel
  localparam int unsigned SETTLE_CYCLES = PIXEL_BITS + 12;
  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned REPORT_LIMIT  = 10;
  // pixels per idle regime in the random part
  localparam int unsigned REGIME_PIXELS = 220;

  // one expected magnitude request on the output stream
  typedef struct {
    logic [MagBits-1:0] mag;
    logic [RowBits-1:0] row;
    logic [ColBits-1:0] col;
    logic [MagBits-1:0] peak;
    logic [MagBits-1:0] trough;
    logic               last;
  } mag_result_t;

  typedef enum {
    TEX_NOISE,
    TEX_BINARY,
    TEX_RAMP,
    TEX_FLAT
  } texture_e;

  // sobel window predictor plus the queue of magnitudes still to arrive
  class sobel_ledger;
    bit [FrameWidthBits-1:0]  width_reg;
    bit [FrameHeightBits-1:0] height_reg;
    bit [7:0]                 row_above [MAX_WIDTH];
    bit [7:0]                 row_two_up [MAX_WIDTH];
    bit [7:0]                 lt, lm, lb, ct, cm, cb;
    int unsigned              col, row;
    int unsigned              peak, trough;
    mag_result_t              pending_mags[$];
    int unsigned              bad_results;
    int unsigned              checked;

    function new();
      width_reg  = FRAME_WIDTH_RESET;
      height_reg = FRAME_HEIGHT_RESET;
      col        = 0;
      row        = 0;
      peak       = 0;
      trough     = MagResetMin;
      {lt, lm, lb, ct, cm, cb} = '0;
      bad_results = 0;
      checked     = 0;
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = data[FrameWidthBits-1:0];
        REG_FRAME_HEIGHT: height_reg = data[FrameHeightBits-1:0];
        default: ;
      endcase
    endfunction

    // bit-by-bit integer square root, result fits in 12 bits
    function int unsigned floor_root(int unsigned n);
      int unsigned res, cand;
      res = 0;
      for (int b = 11; b >= 0; b--) begin
        cand = res | (32'd1 << b);
        if (cand * cand <= n) res = cand;
      end
      return res;
    endfunction

    function void note_pixel(logic [7:0] px, logic fs);
      int unsigned w, h, c, r, mag;
      int          t0, t1, t2, m0, m2, b0, b1, b2, gx, gy;
      mag_result_t e;
      w = width_reg;
      h = height_reg;
      if (w < MinFrameDim) w = MinFrameDim;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      if (h < MinFrameDim) h = MinFrameDim;
      if (h > MaxHeight) h = MaxHeight;
      if (fs) begin
        col    = 0;
        row    = 0;
        peak   = 0;
        trough = MagResetMin;
      end
      c = (col >= MAX_WIDTH) ? MAX_WIDTH - 1 : col;
      r = row;
      // left column, center column, then the right column from the line stores and the new pixel
      t0 = lt;
      m0 = lm;
      b0 = lb;
      t1 = ct;
      b1 = cb;
      t2 = row_two_up[c];
      m2 = row_above[c];
      b2 = px;
      if (r >= 2 && c >= 2) begin
        gx = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
        gy = (b0 + 2 * b1 + b2) - (t0 + 2 * t1 + t2);
        mag = floor_root(gx * gx + gy * gy);
        if (mag > MagSat) mag = MagSat;
        if (mag > peak) peak = mag;
        if (mag < trough) trough = mag;
        e.mag    = MagBits'(mag);
        e.row    = RowBits'(r - 1);
        e.col    = ColBits'(c - 1);
        e.peak   = MagBits'(peak);
        e.trough = MagBits'(trough);
        e.last   = (r + 1 >= h) && (c + 1 >= w);
        pending_mags.push_back(e);
      end
      lt = ct;
      lm = cm;
      lb = cb;
      ct = 8'(t2);
      cm = 8'(m2);
      cb = px;
      row_two_up[c] = 8'(m2);
      row_above[c]  = px;
      if (c + 1 >= w) begin
        col = 0;
        if (r + 1 >= h) begin
          row    = 0;
          peak   = 0;
          trough = MagResetMin;
        end else begin
          row = r + 1;
        end
      end else begin
        col = c + 1;
      end
    endfunction

    function void match_result(logic [OutDataBits-1:0] data, logic last);
      mag_result_t e;
      if (pending_mags.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_LIMIT)
          $display("unexpected magnitude request: tdata %h tlast %b", data, last);
        return;
      end
      e = pending_mags.pop_front();
      checked++;
      if (data[10:0] !== e.mag || data[22:11] !== e.row || data[32:23] !== e.col ||
          data[43:33] !== e.peak || data[54:44] !== e.trough || last !== e.last) begin
        bad_results++;
        if (bad_results <= REPORT_LIMIT)
          $display({"magnitude mismatch at (%0d,%0d): exp mag %0d max %0d min %0d last %b",
                    " / got (%0d,%0d) mag %0d max %0d min %0d last %b"},
                   e.row, e.col, e.mag, e.peak, e.trough, e.last,
                   data[22:11], data[32:23], data[10:0], data[43:33], data[54:44], last);
      end
    endfunction

    function int unsigned outstanding();
      return pending_mags.size();
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic [CfgIdxBits-1:0]    cfg_index_i   = REG_FRAME_WIDTH;
  logic [CfgDataBits-1:0]   cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic [IntensityBits-1:0] s_axis_tdata  = '0;
  logic                     s_axis_tuser  = 1'b0;
  logic                     m_axis_tready = 1'b0;
  logic                     cfg_ready_o;
  logic                     s_axis_tready;
  logic                     m_axis_tvalid;
  logic [OutDataBits-1:0]   m_axis_tdata;
  logic                     m_axis_tlast;

  sobel_ledger ledger = new();

  // percent of cycles each side sits idle in the current regime
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned pixels_sent   = 0;
  int unsigned frames_sent   = 0;
  int unsigned cycles        = 0;

  sobel_gradient_magnitude_top #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d magnitudes outstanding", cycles,
               ledger.outstanding());
      $display("== FAIL ==");
      $finish;
    end
  end

  // magnitude side: check every accepted request, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      ledger.match_result(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // one pixel request; tvalid stays high afterwards until the next call or a drain
  task automatic offer_pixel(input logic [7:0] px, input logic fs);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= fs;
    do @(posedge clk_i); while (!s_axis_tready);
    ledger.note_pixel(px, fs);
    pixels_sent++;
  endtask

  // stop sending and wait until the block has delivered everything and gone quiet
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both size registers, written back to back only while the block is idle
  task automatic program_frame(input logic [CfgDataBits-1:0] wdata,
                               input logic [CfgDataBits-1:0] hdata);
    drain_block();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_FRAME_WIDTH;
    cfg_data_i  <= wdata;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.write_reg(REG_FRAME_WIDTH, wdata);
    cfg_index_i <= REG_FRAME_HEIGHT;
    cfg_data_i  <= hdata;
    do @(posedge clk_i); while (!cfg_ready_o);
    ledger.write_reg(REG_FRAME_HEIGHT, hdata);
    cfg_valid_i <= 1'b0;
  endtask

  // count pixels of a frame ew wide; pause_at < 0 means no mid-frame drain
  task automatic send_frame(input int ew, input int count, input bit fs_first,
                            input texture_e tex, input int pause_at);
    int          r, c;
    int unsigned base, ks, kc;
    logic [7:0]  px;
    base = $urandom_range(0, 255);
    ks   = $urandom_range(0, 64);
    kc   = $urandom_range(0, 64);
    for (int i = 0; i < count; i++) begin
      r = i / ew;
      c = i % ew;
      case (tex)
        TEX_BINARY: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        TEX_RAMP:   px = 8'(base + r * ks + c * kc);
        TEX_FLAT:   px = 8'(base + $urandom_range(0, 3));
        default:    px = 8'($urandom_range(0, 255));
      endcase
      if (i == pause_at) drain_block();
      offer_pixel(px, fs_first && (i == 0));
    end
  endtask

  // random sizes, mostly whole frames, now and then an abandoned one
  task automatic random_phase(input bit force_pause);
    int unsigned            wv, hv, ew, eh, nframes, count;
    int                     pause_at;
    bit                     aligned, broken, fs;
    texture_e               tex;
    logic [CfgDataBits-1:0] wdata;
    wv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
    hv = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
    // bits above the 11-bit width register are dropped by the block
    wdata = CfgDataBits'(wv) | (CfgDataBits'($urandom_range(0, 3)) << FrameWidthBits);
    ew = (wv < MinFrameDim) ? MinFrameDim : wv;
    eh = (hv < MinFrameDim) ? MinFrameDim : hv;
    program_frame(wdata, CfgDataBits'(hv));
    aligned = 1'b0;
    nframes = $urandom_range(1, 3);
    for (int f = 0; f < nframes; f++) begin
      broken = ($urandom_range(0, 9) == 0);
      count  = broken ? $urandom_range(1, ew * eh - 1) : ew * eh;
      // after a whole frame the block wraps on its own, so the mark is optional
      fs     = !aligned || ($urandom_range(0, 3) != 0);
      tex    = texture_e'($urandom_range(0, 3));
      pause_at = ((force_pause && f == 0) || $urandom_range(0, 15) == 0) ? count / 2 : -1;
      send_frame(ew, count, fs, tex, pause_at);
      aligned = !broken;
      if (!broken) frames_sent++;
    end
  endtask

  // directed frames at 3x3: strong corner edge, flat frame entered by wrap,
  // abandoned frame, then a restart with a full-scale left edge
  byte unsigned corner_edge [9] = '{0, 0, 255, 0, 0, 255, 255, 255, 255};
  byte unsigned left_edge   [9] = '{255, 0, 0, 255, 0, 0, 255, 255, 0};

  initial begin
    int unsigned goal;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both registers below range, block clamps to 3x3
    program_frame(CfgDataBits'(0), CfgDataBits'(2));
    for (int i = 0; i < 9; i++) offer_pixel(8'(corner_edge[i]), i == 0);
    // no start mark: frame boundary from the end-of-frame wrap
    for (int i = 0; i < 9; i++) offer_pixel(8'h00, 1'b0);
    offer_pixel(8'hFF, 1'b1);
    for (int i = 0; i < 9; i++) offer_pixel(8'(left_edge[i]), i == 0);
    frames_sent += 3;

    // random part in three idle regimes
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      goal = pixels_sent + REGIME_PIXELS;
      while (pixels_sent < goal) random_phase(regime == 0 && pixels_sent < goal - 200);
    end

    // widest size: width register all ones clamps to the line store size, so a
    // short start of the first row must not wrap or emit anything
    program_frame(13'h1FFF, CfgDataBits'(0));
    send_frame(MAX_WIDTH, 24, 1'b1, TEX_NOISE, -1);
    // tallest size: height register all ones clamps to the row limit, first rows only
    program_frame(CfgDataBits'(3), 13'h1FFF);
    send_frame(MinFrameDim, MinFrameDim * 10, 1'b1, TEX_NOISE, -1);

    drain_block();
    $display("sent %0d pixels in %0d complete frames, checked %0d magnitudes",
             pixels_sent, frames_sent, ledger.checked);
    $display("sizes from clamped 3x3 to 12x8 plus partial 1024-wide and 4096-tall frames, %0d bad",
             ledger.bad_results);
    if (ledger.bad_results == 0 && ledger.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/sgm_pkg.sv
rtl/core/sgm_ram.sv
rtl/core/sgm_isqrt.sv
rtl/core/sobel_gradient_magnitude_top.sv
rtl/core/sgm_checker.sv
tb/testbench.sv
